### src/clock_second_chance_victim_select_assert.svh
// ----------------------------------------------------------------------------
// Assertion macros for the clock victim selector
// Shared property forms, clocked on aclk and held off while aresetn is low.
// ----------------------------------------------------------------------------
`ifndef CLOCK_SECOND_CHANCE_VICTIM_SELECT_ASSERT_SVH
`define CLOCK_SECOND_CHANCE_VICTIM_SELECT_ASSERT_SVH

// Same-cycle implication.
`define CVS_ASSERT_NOW(label, ante, cons) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error("same-cycle check failed");

// Next-cycle implication.
`define CVS_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error("next-cycle check failed");

`endif

### src/cvs_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cvs_pkg
// Types, sizes and codes of the clock (second chance) victim selector.
// ----------------------------------------------------------------------------
package cvs_pkg;

    localparam int MAX_SLOTS = 16;
    localparam int SLOT_W    = $clog2(MAX_SLOTS);
    localparam int NUM_W     = $clog2(MAX_SLOTS + 1);
    localparam int STEP_W    = $clog2(2 * MAX_SLOTS + 1);

    localparam int CMD_W     = 3;
    localparam int SLOT_IN_W = 4;
    localparam int STATUS_W  = 2;
    localparam int VICTIM_W  = 4;
    localparam int FIX_W     = 4;
    localparam int CFG_W     = 5;
    localparam int CFG_IDX_W = 1;

    localparam logic [FIX_W-1:0] FIX_MAX = '1;

    // Commands
    localparam logic [CMD_W-1:0] CMD_ALLOCATE  = 3'd0;
    localparam logic [CMD_W-1:0] CMD_REFERENCE = 3'd1;
    localparam logic [CMD_W-1:0] CMD_FIX       = 3'd2;
    localparam logic [CMD_W-1:0] CMD_UNFIX     = 3'd3;
    localparam logic [CMD_W-1:0] CMD_DIRTY     = 3'd4;
    localparam logic [CMD_W-1:0] CMD_CLEAN     = 3'd5;

    // Status codes
    localparam logic [STATUS_W-1:0] STATUS_OK          = 2'd0;
    localparam logic [STATUS_W-1:0] STATUS_NO_UNFIXED  = 2'd1;
    localparam logic [STATUS_W-1:0] STATUS_UNSUPPORTED = 2'd2;

    // Configuration register indexes
    localparam logic [CFG_IDX_W-1:0] REG_SLOTS_IN_USE = 1'd0;
    localparam logic [CFG_IDX_W-1:0] REG_BULK_FLUSH   = 1'd1;

    typedef struct packed {
        logic [CMD_W-1:0]     command;
        logic [SLOT_IN_W-1:0] slot;
    } cvs_req_t;

    typedef struct packed {
        logic [STATUS_W-1:0] status;
        logic [VICTIM_W-1:0] victim;
        logic                flush_needed;
        logic                delete_needed;
    } cvs_rsp_t;

    typedef struct packed {
        logic             ref_bit;
        logic [FIX_W-1:0] fix_count;
        logic             dirty;
        logic             valid;
    } slot_entry_t;

endpackage

### src/clock_second_chance_victim_select.sv
// Flow: a non-allocate request updates its slot, then loads its response;
// an allocate sweeps at most 2*N slots, N being the slots in use.
// Throughput: one request at a time; the next is taken once the response is
// loaded, which waits while the output register is full; an allocate is
// bound by the single slot-table port that the hand walks one slot per cycle.
// Reset (aresetn low, synchronous) clears all slot bits and the hand at once.
`timescale 1ns / 1ps
`include "clock_second_chance_victim_select_assert.svh"
// ----------------------------------------------------------------------------
// clock_second_chance_victim_select
// Buffer-pool victim selector under the clock (second chance) rule. A small
// sequencer steps one shared slot-table port and hand incrementer.
// ----------------------------------------------------------------------------
module clock_second_chance_victim_select
    import cvs_pkg::*;
(
    input  logic                 aclk,
    input  logic                 aresetn,
    // configuration writes
    input  logic                 cfg_wr_en,
    input  logic [CFG_IDX_W-1:0] cfg_addr,
    input  logic [CFG_W-1:0]     cfg_wdata,
    // request channel
    input  logic                 s_valid,
    output logic                 s_ready,
    input  cvs_req_t             s_req,
    // response channel
    output logic                 m_valid,
    input  logic                 m_ready,
    output cvs_rsp_t             m_rsp
);

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_UPDATE,
        ST_SWEEP,
        ST_FINISH
    } state_t;

    state_t                 state_reg, state_next;
    slot_entry_t            tbl_reg  [MAX_SLOTS];
    slot_entry_t            tbl_next [MAX_SLOTS];
    logic [SLOT_W-1:0]      clock_hand_reg, clock_hand_next;
    logic [CFG_W-1:0]       slots_in_use_reg, slots_in_use_next;
    logic                   bulk_flush_reg, bulk_flush_next;
    logic                   m_valid_reg, m_valid_next;
    cvs_rsp_t               m_rsp_reg, m_rsp_next;

    // per-request working registers
    logic [CMD_W-1:0]       cmd_reg, cmd_next;
    logic [SLOT_W-1:0]      slot_reg, slot_next;
    logic [SLOT_W-1:0]      hand_reg, hand_next;
    logic [NUM_W-1:0]       n_reg, n_next;
    logic [STEP_W-1:0]      step_reg, step_next;
    cvs_rsp_t               rsp_reg, rsp_next;

    logic [NUM_W-1:0]       n_eff;
    logic [NUM_W-1:0]       hand_p1;
    logic [SLOT_W-1:0]      hand_inc;
    logic [SLOT_W-1:0]      rd_idx;
    slot_entry_t            cur;
    slot_entry_t            upd;
    logic                   slot_ok;

    assign s_ready = (state_reg == ST_IDLE);
    assign m_valid = m_valid_reg;
    assign m_rsp   = m_rsp_reg;

    // Clamp the slots-in-use register into 1..MAX_SLOTS.
    always_comb begin
        if (slots_in_use_reg == '0) begin
            n_eff = NUM_W'(1);
        end else if (32'(slots_in_use_reg) > 32'(MAX_SLOTS)) begin
            n_eff = NUM_W'(MAX_SLOTS);
        end else begin
            n_eff = NUM_W'(slots_in_use_reg);
        end
    end

    // Shared hand incrementer, wrapping at the slots in use.
    assign hand_p1  = NUM_W'(hand_reg) + NUM_W'(1);
    assign hand_inc = (hand_p1 == n_reg) ? '0 : SLOT_W'(hand_p1);

    // Single table read port: the hand during a sweep, else the request slot.
    assign rd_idx  = (state_reg == ST_SWEEP) ? hand_reg : slot_reg;
    assign cur     = tbl_reg[rd_idx];
    assign slot_ok = 32'(s_req.slot) < 32'(MAX_SLOTS);

    always_comb begin
        state_next        = state_reg;
        tbl_next          = tbl_reg;
        clock_hand_next   = clock_hand_reg;
        slots_in_use_next = slots_in_use_reg;
        bulk_flush_next   = bulk_flush_reg;
        m_valid_next      = m_valid_reg;
        m_rsp_next        = m_rsp_reg;
        cmd_next          = cmd_reg;
        slot_next         = slot_reg;
        hand_next         = hand_reg;
        n_next            = n_reg;
        step_next         = step_reg;
        rsp_next          = rsp_reg;
        upd               = cur;

        // Unguarded configuration writes; the user issues them only while idle.
        if (cfg_wr_en) begin
            case (cfg_addr)
                REG_SLOTS_IN_USE: slots_in_use_next = cfg_wdata;
                REG_BULK_FLUSH:   bulk_flush_next   = cfg_wdata[0];
                default:          ;
            endcase
        end

        // Drop the response once the consumer takes it.
        if (m_valid_reg && m_ready) begin
            m_valid_next = 1'b0;
        end

        case (state_reg)
            ST_IDLE: begin
                if (s_valid) begin
                    cmd_next  = s_req.command;
                    slot_next = SLOT_W'(s_req.slot);
                    n_next    = n_eff;
                    // A hand left beyond a lowered slot count restarts at slot 0.
                    hand_next = (NUM_W'(clock_hand_reg) >= n_eff) ? '0 : clock_hand_reg;
                    step_next = '0;
                    rsp_next  = '0;
                    if (s_req.command == CMD_ALLOCATE) begin
                        if (bulk_flush_reg) begin
                            rsp_next.status = STATUS_UNSUPPORTED;
                            state_next      = ST_FINISH;
                        end else begin
                            state_next = ST_SWEEP;
                        end
                    end else if (slot_ok) begin
                        state_next = ST_UPDATE;
                    end else begin
                        state_next = ST_FINISH;
                    end
                end
            end

            ST_UPDATE: begin
                case (cmd_reg)
                    CMD_REFERENCE: begin
                        upd.ref_bit = 1'b1;
                        upd.valid   = 1'b1;
                    end
                    CMD_FIX: begin
                        if (cur.fix_count != FIX_MAX) begin
                            upd.fix_count = cur.fix_count + FIX_W'(1);
                        end
                    end
                    CMD_UNFIX: begin
                        if (cur.fix_count != '0) begin
                            upd.fix_count = cur.fix_count - FIX_W'(1);
                        end
                    end
                    CMD_DIRTY: upd.dirty = 1'b1;
                    CMD_CLEAN: upd.dirty = 1'b0;
                    default:   ;
                endcase
                tbl_next[slot_reg] = upd;
                state_next         = ST_FINISH;
            end

            ST_SWEEP: begin
                if (step_reg == STEP_W'({n_reg, 1'b0})) begin
                    // Two full sweeps without a victim: leave the hand here.
                    clock_hand_next = hand_reg;
                    rsp_next.status = STATUS_NO_UNFIXED;
                    state_next      = ST_FINISH;
                end else if (cur.fix_count == '0 && !cur.ref_bit) begin
                    rsp_next.status        = STATUS_OK;
                    rsp_next.victim        = VICTIM_W'(hand_reg);
                    rsp_next.flush_needed  = cur.dirty;
                    rsp_next.delete_needed = cur.valid;
                    upd.dirty              = 1'b0;
                    upd.valid              = 1'b0;
                    tbl_next[hand_reg]     = upd;
                    clock_hand_next        = hand_inc;
                    state_next             = ST_FINISH;
                end else begin
                    // Second chance: clear the reference bit of an unfixed slot.
                    if (cur.fix_count == '0) begin
                        upd.ref_bit        = 1'b0;
                        tbl_next[hand_reg] = upd;
                    end
                    hand_next = hand_inc;
                    step_next = step_reg + STEP_W'(1);
                end
            end

            ST_FINISH: begin
                // Hold the result until the output register is free.
                if (!m_valid_reg || m_ready) begin
                    m_valid_next = 1'b1;
                    m_rsp_next   = rsp_reg;
                    state_next   = ST_IDLE;
                end
            end

            default: state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg        <= ST_IDLE;
            for (int i = 0; i < MAX_SLOTS; i++) begin
                tbl_reg[i] <= '0;
            end
            clock_hand_reg   <= '0;
            slots_in_use_reg <= CFG_W'(MAX_SLOTS);
            bulk_flush_reg   <= 1'b0;
            m_valid_reg      <= 1'b0;
        end else begin
            state_reg        <= state_next;
            tbl_reg          <= tbl_next;
            clock_hand_reg   <= clock_hand_next;
            slots_in_use_reg <= slots_in_use_next;
            bulk_flush_reg   <= bulk_flush_next;
            m_valid_reg      <= m_valid_next;
            m_rsp_reg        <= m_rsp_next;
            cmd_reg          <= cmd_next;
            slot_reg         <= slot_next;
            hand_reg         <= hand_next;
            n_reg            <= n_next;
            step_reg         <= step_next;
            rsp_reg          <= rsp_next;
        end
    end

    // ------------------------------------------------------------------------
    // Assertions
    // ------------------------------------------------------------------------
    // An error response carries no victim information.
    `CVS_ASSERT_NOW(a_err_fields_zero,
        m_valid_reg && m_rsp_reg.status != STATUS_OK,
        m_rsp_reg.victim == '0 && !m_rsp_reg.flush_needed && !m_rsp_reg.delete_needed)
    // The sweep never runs past two rounds.
    `CVS_ASSERT_NOW(a_sweep_bound,
        state_reg == ST_SWEEP,
        32'(step_reg) <= 2 * 32'(n_reg))
    // The hand stays within the slots in use while sweeping.
    `CVS_ASSERT_NOW(a_hand_in_range,
        state_reg == ST_SWEEP,
        NUM_W'(hand_reg) < n_reg && n_reg != '0)
    // An allocate in bulk-flush mode goes straight to the response.
    `CVS_ASSERT_NEXT(a_bulk_refused,
        s_valid && s_ready && s_req.command == CMD_ALLOCATE && bulk_flush_reg,
        state_reg == ST_FINISH && rsp_reg.status == STATUS_UNSUPPORTED)

endmodule

### dv/tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the clock (second chance) victim selector. Requests
// are queued phase by phase, each phase under its own slots-in-use and
// bulk-flush setting. A clocked driver offers them with random gaps, a clocked
// monitor takes responses with random stalls, and an in-bench copy of the
// slot table predicts every response at the moment its request is taken.
// ----------------------------------------------------------------------------
module tb;
    import cvs_pkg::*;

    // Command codes the block leaves unused; they must change nothing.
    localparam logic [CMD_W-1:0] CMD_SPARE_LO = 3'd6;
    localparam logic [CMD_W-1:0] CMD_SPARE_HI = 3'd7;

    // Settle for longer than the longest allocate, a sweep of at most 2*N slots.
    localparam int SETTLE_CYCLES = 2 * MAX_SLOTS + 8;
    localparam int PHASE_ITEMS   = 80;
    localparam int SQUEEZE_AT    = 60;
    localparam int SQUEEZE_LEN   = 400;

    logic                 aclk;
    logic                 aresetn   = 1'b0;
    logic                 cfg_wr_en = 1'b0;
    logic [CFG_IDX_W-1:0] cfg_addr  = '0;
    logic [CFG_W-1:0]     cfg_wdata = '0;
    logic                 s_valid   = 1'b0;
    logic                 s_ready;
    cvs_req_t             s_req     = '0;
    logic                 m_valid;
    logic                 m_ready   = 1'b0;
    cvs_rsp_t             m_rsp;

    clock_second_chance_victim_select DUT (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_wr_en (cfg_wr_en),
        .cfg_addr  (cfg_addr),
        .cfg_wdata (cfg_wdata),
        .s_valid   (s_valid),
        .s_ready   (s_ready),
        .s_req     (s_req),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .m_rsp     (m_rsp)
    );

    // ------------------------------------------------------------------------
    // Shadow of the slot table, the hand and both registers
    // ------------------------------------------------------------------------
    logic             ref_bit   [MAX_SLOTS];
    logic [FIX_W-1:0] fix_cnt   [MAX_SLOTS];
    logic             dirty_bit [MAX_SLOTS];
    logic             valid_bit [MAX_SLOTS];
    int               hand      = 0;
    logic [CFG_W-1:0] cfg_slots = 5'd16;
    logic             cfg_bulk  = 1'b0;

    cvs_req_t req_backlog [$];     // requests waiting to be offered
    cvs_rsp_t due_responses [$];   // predicted responses, oldest first

    int  mismatch_cnt = 0;
    bit  calm         = 1'b0;      // set for the closing phase: no gaps, no stalls

    initial begin
        aclk = 1'b0;
        forever #5 aclk = ~aclk;
    end

    initial begin
        for (int i = 0; i < MAX_SLOTS; i++) begin
            ref_bit[i]   = 1'b0;
            fix_cnt[i]   = '0;
            dirty_bit[i] = 1'b0;
            valid_bit[i] = 1'b0;
        end
    end

    // Slots the hand sweeps: a zero register acts as one, an oversized one
    // as the full table.
    function automatic int active_slots();
        if (cfg_slots == 0)
            return 1;
        if (cfg_slots > MAX_SLOTS)
            return MAX_SLOTS;
        return int'(cfg_slots);
    endfunction

    // Apply one request to the shadow table and work out its response.
    task automatic apply_command(input cvs_req_t req, output cvs_rsp_t rsp);
        int n;
        int h;
        int steps;
        bit found;
        rsp   = '0;
        found = 1'b0;
        case (req.command)
            CMD_ALLOCATE: begin
                if (cfg_bulk) begin
                    rsp.status = STATUS_UNSUPPORTED;
                end else begin
                    n = active_slots();
                    h = (hand >= n) ? 0 : hand;
                    // Walk at most two sweeps; skip fixed slots, strip
                    // reference bits, stop on the first clear unfixed slot.
                    for (steps = 0; steps < 2 * n && !found; steps++) begin
                        if (fix_cnt[h] == 0 && !ref_bit[h])
                            found = 1'b1;
                        else begin
                            if (fix_cnt[h] == 0)
                                ref_bit[h] = 1'b0;
                            h = (h + 1) % n;
                        end
                    end
                    if (found) begin
                        rsp.status        = STATUS_OK;
                        rsp.victim        = h[VICTIM_W-1:0];
                        rsp.flush_needed  = dirty_bit[h];
                        rsp.delete_needed = valid_bit[h];
                        dirty_bit[h]      = 1'b0;
                        valid_bit[h]      = 1'b0;
                        hand              = (h + 1) % n;
                    end else begin
                        rsp.status = STATUS_NO_UNFIXED;
                        hand       = h;
                    end
                end
            end
            CMD_REFERENCE: begin
                ref_bit[req.slot]   = 1'b1;
                valid_bit[req.slot] = 1'b1;
            end
            CMD_FIX: begin
                if (fix_cnt[req.slot] != FIX_MAX)
                    fix_cnt[req.slot] = fix_cnt[req.slot] + 1'b1;
            end
            CMD_UNFIX: begin
                if (fix_cnt[req.slot] != 0)
                    fix_cnt[req.slot] = fix_cnt[req.slot] - 1'b1;
            end
            CMD_DIRTY: dirty_bit[req.slot] = 1'b1;
            CMD_CLEAN: dirty_bit[req.slot] = 1'b0;
            default: ;
        endcase
    endtask

    task automatic report(input string what);
        $display("[%0t] mismatch: %s", $realtime, what);
        mismatch_cnt++;
    endtask

    task automatic queue_req(input logic [CMD_W-1:0] cmd, input logic [SLOT_IN_W-1:0] slot);
        cvs_req_t r;
        r.command = cmd;
        r.slot    = slot;
        req_backlog.push_back(r);
    endtask

    // Mostly slots inside the swept range, now and then anywhere in the table.
    function automatic logic [SLOT_IN_W-1:0] pick_slot(input int n);
        if ($urandom_range(0, 3) != 0)
            return SLOT_IN_W'($urandom_range(0, n - 1));
        return SLOT_IN_W'($urandom_range(0, MAX_SLOTS - 1));
    endfunction

    // Fill the backlog for one phase: loose single requests mixed with
    // sequences that reach saturation, a fully fixed pool and full sweeps.
    task automatic queue_phase(input int count);
        int n;
        int added;
        int pick;
        int s;
        int reps;
        logic [CMD_W-1:0] cmd;
        n     = active_slots();
        added = 0;
        while (added < count) begin
            pick = $urandom_range(0, 99);
            if (pick < 70) begin
                case ($urandom_range(0, 19))
                    0, 1, 2, 3, 4, 5: cmd = CMD_ALLOCATE;
                    6, 7, 8, 9:       cmd = CMD_REFERENCE;
                    10, 11, 12:       cmd = CMD_FIX;
                    13, 14, 15:       cmd = CMD_UNFIX;
                    16:               cmd = CMD_DIRTY;
                    17:               cmd = CMD_CLEAN;
                    18:               cmd = CMD_SPARE_LO;
                    default:          cmd = CMD_SPARE_HI;
                endcase
                queue_req(cmd, pick_slot(n));
                added++;
            end else if (pick < 80) begin
                // Pin one slot up to or past the fix ceiling, allocate, then release
                // it past zero.
                s    = $urandom_range(0, n - 1);
                reps = $urandom_range(14, 17);
                repeat (reps) queue_req(CMD_FIX, SLOT_IN_W'(s));
                queue_req(CMD_ALLOCATE, pick_slot(MAX_SLOTS));
                repeat (reps + 1) queue_req(CMD_UNFIX, SLOT_IN_W'(s));
                added += 2 * reps + 2;
            end else if (pick < 90) begin
                // Fix every swept slot so allocate finds nothing, then release.
                for (int k = 0; k < n; k++)
                    queue_req(CMD_FIX, SLOT_IN_W'(k));
                queue_req(CMD_ALLOCATE, pick_slot(MAX_SLOTS));
                queue_req(CMD_ALLOCATE, pick_slot(MAX_SLOTS));
                for (int k = 0; k < n; k++)
                    queue_req(CMD_UNFIX, SLOT_IN_W'(k));
                added += 2 * n + 2;
            end else begin
                // Reference every swept slot, dirty some, then allocate so the
                // hand strips a full sweep before choosing.
                for (int k = 0; k < n; k++) begin
                    queue_req(CMD_REFERENCE, SLOT_IN_W'(k));
                    if ($urandom_range(0, 1))
                        queue_req(CMD_DIRTY, SLOT_IN_W'(k));
                end
                reps = $urandom_range(1, 3);
                repeat (reps) queue_req(CMD_ALLOCATE, pick_slot(MAX_SLOTS));
                added += n + reps;
            end
        end
    endtask

    // Hold until every request is taken and every response has come back,
    // then let the block settle. Sample between edges so the driver's and
    // monitor's updates of this edge are already in.
    task automatic wait_drained();
        do
            @(negedge aclk);
        while (req_backlog.size() != 0 || s_valid || due_responses.size() != 0);
        repeat (SETTLE_CYCLES) @(posedge aclk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_W-1:0] val);
        @(posedge aclk);
        cfg_wr_en <= 1'b1;
        cfg_addr  <= idx;
        cfg_wdata <= val;
        if (idx == REG_SLOTS_IN_USE)
            cfg_slots = val;
        else
            cfg_bulk = val[0];
    endtask

    // ------------------------------------------------------------------------
    // Driver: offer the backlog, predict each request as it is taken
    // ------------------------------------------------------------------------
    always @(posedge aclk) begin : drive_requests
        int       gap_left;
        cvs_rsp_t predicted;
        if (!aresetn) begin
            s_valid  <= 1'b0;
            s_req    <= '0;
            gap_left = 0;
        end else begin
            if (s_valid && s_ready) begin
                apply_command(s_req, predicted);
                due_responses.push_back(predicted);
            end
            // Payload and valid only move once the current request is gone.
            if (!s_valid || s_ready) begin
                if (gap_left > 0) begin
                    gap_left--;
                    s_valid <= 1'b0;
                end else if (req_backlog.size() != 0) begin
                    s_valid <= 1'b1;
                    s_req   <= req_backlog.pop_front();
                    if (!calm && $urandom_range(0, 5) == 0)
                        gap_left = $urandom_range(1, 15);
                end else begin
                    s_valid <= 1'b0;
                end
            end
        end
    end

    // ------------------------------------------------------------------------
    // Monitor: take responses with random stalls, one long hold-off, and
    // check each against the oldest prediction
    // ------------------------------------------------------------------------
    always @(posedge aclk) begin : check_responses
        int       stall_left;
        int       seen_cnt;
        bit       squeezed;
        cvs_rsp_t want;
        if (!aresetn) begin
            m_ready    <= 1'b0;
            stall_left = 0;
            seen_cnt   = 0;
            squeezed   = 1'b0;
        end else begin
            if (m_valid && m_ready) begin
                seen_cnt++;
                if (due_responses.size() == 0) begin
                    report($sformatf("response with nothing outstanding: %p", m_rsp));
                end else begin
                    want = due_responses.pop_front();
                    if (m_rsp.status !== want.status)
                        report($sformatf("status %0d, predicted %0d",
                                         m_rsp.status, want.status));
                    if (m_rsp.victim !== want.victim)
                        report($sformatf("victim %0d, predicted %0d",
                                         m_rsp.victim, want.victim));
                    if (m_rsp.flush_needed !== want.flush_needed)
                        report($sformatf("flush_needed %b, predicted %b",
                                         m_rsp.flush_needed, want.flush_needed));
                    if (m_rsp.delete_needed !== want.delete_needed)
                        report($sformatf("delete_needed %b, predicted %b",
                                         m_rsp.delete_needed, want.delete_needed));
                end
            end
            // Hold off for a long stretch once, so the block backs up into
            // its request port while the driver keeps offering.
            if (!squeezed && seen_cnt == SQUEEZE_AT) begin
                squeezed   = 1'b1;
                stall_left = SQUEEZE_LEN;
            end
            if (stall_left > 0) begin
                stall_left--;
                m_ready <= 1'b0;
            end else if (!calm && $urandom_range(0, 6) == 0) begin
                stall_left = $urandom_range(0, 14);
                m_ready    <= 1'b0;
            end else begin
                m_ready <= 1'b1;
            end
        end
    end

    // ------------------------------------------------------------------------
    // Sequence: reset, directed requests, then one random phase per setting
    // ------------------------------------------------------------------------
    initial begin : run_phases
        logic [CFG_W-1:0] phase_slots [9];
        logic             phase_bulk  [9];
        phase_slots = '{5'd16, 5'd1, 5'd3, 5'd16, 5'd0, 5'd31, 5'd5, 5'd2, 5'd16};
        phase_bulk  = '{1'b0,  1'b0, 1'b0, 1'b1,  1'b0, 1'b0,  1'b1, 1'b0, 1'b0};

        repeat (2) @(posedge aclk);
        aresetn <= 1'b1;

        // Directed: allocate on an empty pool, flag changes at both table
        // ends, fix and unfix at the floor, the spare codes, short sweeps.
        queue_req(CMD_ALLOCATE,  4'd9);
        queue_req(CMD_REFERENCE, 4'd0);
        queue_req(CMD_DIRTY,     4'd0);
        queue_req(CMD_REFERENCE, 4'd15);
        queue_req(CMD_DIRTY,     4'd15);
        queue_req(CMD_CLEAN,     4'd15);
        queue_req(CMD_FIX,       4'd1);
        queue_req(CMD_FIX,       4'd1);
        queue_req(CMD_UNFIX,     4'd1);
        queue_req(CMD_UNFIX,     4'd2);
        queue_req(CMD_SPARE_LO,  4'd15);
        queue_req(CMD_SPARE_HI,  4'd0);
        queue_req(CMD_ALLOCATE,  4'd0);
        queue_req(CMD_REFERENCE, 4'd3);
        queue_req(CMD_ALLOCATE,  4'd15);
        queue_req(CMD_REFERENCE, 4'd6);
        queue_req(CMD_DIRTY,     4'd6);
        queue_req(CMD_ALLOCATE,  4'd0);
        queue_req(CMD_ALLOCATE,  4'd0);
        queue_req(CMD_ALLOCATE,  4'd0);
        queue_req(CMD_UNFIX,     4'd1);
        wait_drained();

        for (int p = 0; p < 9; p++) begin
            write_reg(REG_SLOTS_IN_USE, phase_slots[p]);
            write_reg(REG_BULK_FLUSH, {{(CFG_W - 1){1'b0}}, phase_bulk[p]});
            @(posedge aclk);
            cfg_wr_en <= 1'b0;
            if (p == 8)
                calm = 1'b1;
            queue_phase(PHASE_ITEMS);
            wait_drained();
        end

        if (due_responses.size() != 0)
            report($sformatf("%0d responses never arrived", due_responses.size()));
        if (mismatch_cnt == 0)
            $display("PASS");
        else
            $display("FAIL");
        $finish;
    end

    // Generous ceiling well past the slowest legal run.
    initial begin : watchdog
        #5_000_000;
        $display("FAIL");
        $finish;
    end

endmodule
